// ===== rtl/tsgd_pkg.sv =====
// tsgd_pkg: shared types and constants of the simple glyph point decoder
// no dependencies
`timescale 1ns / 1ps

package tsgd_pkg;

    localparam int unsigned HEADER_BYTES = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COMPOSITE = 2'd1,
        ST_TOO_MANY  = 2'd2,
        ST_OVERRUN   = 2'd3
    } status_t;

    // flag bits of a glyph point
    localparam int unsigned FL_ON_CURVE = 0;
    localparam int unsigned FL_X_SHORT  = 1;
    localparam int unsigned FL_Y_SHORT  = 2;
    localparam int unsigned FL_REPEAT   = 3;
    localparam int unsigned FL_X_SAME   = 4;
    localparam int unsigned FL_Y_SAME   = 5;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               on_curve;
        logic [15:0]        point_index;
        logic               last_point;
        status_t            status;
    } res_t;

    typedef struct packed {
        logic flag_we;
        logic x_we;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/tsgd_store.sv =====
// tsgd_store: flag store and x store on a single shared address, registered read
// depends on tsgd_pkg
`timescale 1ns / 1ps

module tsgd_store #(
    parameter int AW = 10
) (
    input  logic                clk,
    input  tsgd_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       addr,
    input  logic [7:0]          flag_wdata,
    input  logic [15:0]         x_wdata,
    output logic [7:0]          flag_rd,
    output logic [15:0]         x_rd
);

    localparam int DEPTH = 1 << AW;

    logic [7:0]  flag_mem [DEPTH];
    logic [15:0] x_mem    [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.flag_we)
        begin
            flag_mem[addr] <= flag_wdata;
        end
        if (ctl.rd_en)
        begin
            flag_rd <= flag_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.x_we)
        begin
            x_mem[addr] <= x_wdata;
        end
        if (ctl.rd_en)
        begin
            x_rd <= x_mem[addr];
        end
    end

endmodule

// ===== rtl/tsgd_ctrl.sv =====
// tsgd_ctrl: byte parser and point sequencer, drives the stores
// depends on tsgd_pkg
`timescale 1ns / 1ps

module tsgd_ctrl #(
    parameter int AW = 10,
    parameter int CW = 11,
    parameter int MAX_POINTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                glyph_start,
    output logic                ready,
    output logic                res_valid,
    output tsgd_pkg::res_t      res,
    output tsgd_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]       mem_addr,
    output logic [7:0]          flag_wdata,
    output logic [15:0]         x_wdata,
    input  logic [7:0]          flag_rd,
    input  logic [15:0]         x_rd
);

    localparam int SW = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_HEADER = 13'b0000000000010,
        S_ENDPTS = 13'b0000000000100,
        S_ILEN   = 13'b0000000001000,
        S_INSTR  = 13'b0000000010000,
        S_FLAG   = 13'b0000000100000,
        S_REPEAT = 13'b0000001000000,
        S_FILL   = 13'b0000010000000,
        S_XRD    = 13'b0000100000000,
        S_XCHK   = 13'b0001000000000,
        S_XIN    = 13'b0010000000000,
        S_YRD    = 13'b0100000000000,
        S_YIN    = 13'b1000000000000
    } state_t;

    state_t      state_reg, state_next, st;
    logic [15:0] bc_reg, bc_next;
    logic [15:0] cc_reg, cc_next;
    logic [CW-1:0] total_reg, total_next;
    logic [15:0] instr_reg, instr_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [7:0]  rep_flag_reg, rep_flag_next;
    logic [7:0]  rep_cnt_reg, rep_cnt_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] rx_reg, rx_next;
    logic [15:0] ry_reg, ry_next;

    logic [CW:0]   cur_inc;
    logic [15:0]   cc_word;
    logic [16:0]   total_raw;
    logic [15:0]   instr_dec;
    logic [SW-1:0] rep_end;
    logic [15:0]   delta;
    logic          delta_done;
    logic          y_skip;
    logic [15:0]   y_new;
    logic [15:0]   x_new;

    assign cur_inc   = {1'b0, cur_reg} + {{CW{1'b0}}, 1'b1};
    assign cc_word   = {high_reg, data_byte};
    assign total_raw = {1'b0, high_reg, data_byte} + 17'd1;
    assign instr_dec = instr_reg - 16'd1;
    assign rep_end   = SW'(cur_reg) + SW'(data_byte);
    assign y_skip    = !flag_rd[tsgd_pkg::FL_Y_SHORT] && flag_rd[tsgd_pkg::FL_Y_SAME];
    assign ready     = !(state_reg == S_FILL || state_reg == S_XRD ||
                         state_reg == S_XCHK || state_reg == S_YRD);

    // delta of one coordinate byte, short form or second byte of a long one
    always_comb
    begin
        delta      = '0;
        delta_done = 1'b0;
        if (state_reg == S_XIN)
        begin
            if (flag_rd[tsgd_pkg::FL_X_SHORT])
            begin
                delta      = flag_rd[tsgd_pkg::FL_X_SAME] ? {8'h00, data_byte}
                                                          : 16'h0000 - {8'h00, data_byte};
                delta_done = 1'b1;
            end
            else if (bc_reg != 16'd0)
            begin
                delta      = {high_reg, data_byte};
                delta_done = 1'b1;
            end
        end
        else
        begin
            if (flag_rd[tsgd_pkg::FL_Y_SHORT])
            begin
                delta      = flag_rd[tsgd_pkg::FL_Y_SAME] ? {8'h00, data_byte}
                                                          : 16'h0000 - {8'h00, data_byte};
                delta_done = 1'b1;
            end
            else if (bc_reg != 16'd0)
            begin
                delta      = {high_reg, data_byte};
                delta_done = 1'b1;
            end
        end
    end

    assign x_new = rx_reg + delta;
    assign y_new = y_skip ? ry_reg : ry_reg + delta;

    always_comb
    begin
        state_next    = state_reg;
        bc_next       = bc_reg;
        cc_next       = cc_reg;
        total_next    = total_reg;
        instr_next    = instr_reg;
        cur_next      = cur_reg;
        rep_flag_next = rep_flag_reg;
        rep_cnt_next  = rep_cnt_reg;
        high_next     = high_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        mem_ctl       = '0;
        mem_addr      = cur_reg[AW-1:0];
        flag_wdata    = data_byte;
        x_wdata       = rx_reg;
        res_valid     = 1'b0;
        res           = '0;

        st = state_reg;
        if (in_fire && glyph_start)
        begin
            st      = S_HEADER;
            bc_next = '0;
            rx_next = '0;
            ry_next = '0;
        end

        unique case (st)
            S_IDLE:
            begin
            end
            S_HEADER:
            begin
                if (in_fire)
                begin
                    state_next = S_HEADER;
                    if (bc_next == 16'd0)
                    begin
                        high_next = data_byte;
                    end
                    if (bc_next == 16'd1 && (cc_word == 16'd0 || cc_word[15]))
                    begin
                        cc_next          = cc_word;
                        res_valid        = 1'b1;
                        res.last_point   = 1'b1;
                        res.status       = tsgd_pkg::ST_COMPOSITE;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        if (bc_next == 16'd1)
                        begin
                            cc_next = cc_word;
                        end
                        if (bc_next + 16'd1 >= 16'(tsgd_pkg::HEADER_BYTES))
                        begin
                            bc_next    = '0;
                            state_next = S_ENDPTS;
                        end
                        else
                        begin
                            bc_next = bc_next + 16'd1;
                        end
                    end
                end
            end
            S_ENDPTS:
            begin
                if (in_fire)
                begin
                    if (!bc_reg[0])
                    begin
                        high_next = data_byte;
                        bc_next   = bc_reg + 16'd1;
                    end
                    else if ({1'b0, bc_reg} + 17'd1 >= {cc_reg, 1'b0})
                    begin
                        if (total_raw > 17'(MAX_POINTS))
                        begin
                            res_valid      = 1'b1;
                            res.last_point = 1'b1;
                            res.status     = tsgd_pkg::ST_TOO_MANY;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            total_next = CW'(total_raw);
                            bc_next    = '0;
                            state_next = S_ILEN;
                        end
                    end
                    else
                    begin
                        bc_next = bc_reg + 16'd1;
                    end
                end
            end
            S_ILEN:
            begin
                if (in_fire)
                begin
                    if (bc_reg == 16'd0)
                    begin
                        high_next = data_byte;
                        bc_next   = 16'd1;
                    end
                    else
                    begin
                        instr_next = cc_word;
                        bc_next    = '0;
                        if (cc_word == 16'd0)
                        begin
                            cur_next   = '0;
                            state_next = S_FLAG;
                        end
                        else
                        begin
                            state_next = S_INSTR;
                        end
                    end
                end
            end
            S_INSTR:
            begin
                if (in_fire)
                begin
                    instr_next = instr_dec;
                    if (instr_dec == 16'd0)
                    begin
                        cur_next   = '0;
                        state_next = S_FLAG;
                    end
                end
            end
            S_FLAG:
            begin
                if (in_fire)
                begin
                    rep_flag_next   = data_byte;
                    mem_ctl.flag_we = 1'b1;
                    cur_next        = CW'(cur_inc);
                    if (data_byte[tsgd_pkg::FL_REPEAT])
                    begin
                        state_next = S_REPEAT;
                    end
                    else if (cur_inc >= {1'b0, total_reg})
                    begin
                        cur_next   = '0;
                        rx_next    = '0;
                        bc_next    = '0;
                        state_next = S_XRD;
                    end
                end
            end
            S_REPEAT:
            begin
                if (in_fire)
                begin
                    if (rep_end > SW'(total_reg))
                    begin
                        res_valid      = 1'b1;
                        res.last_point = 1'b1;
                        res.status     = tsgd_pkg::ST_OVERRUN;
                        state_next     = S_IDLE;
                    end
                    else if (data_byte != 8'd0)
                    begin
                        rep_cnt_next = data_byte;
                        state_next   = S_FILL;
                    end
                    else if (cur_reg >= total_reg)
                    begin
                        cur_next   = '0;
                        rx_next    = '0;
                        bc_next    = '0;
                        state_next = S_XRD;
                    end
                    else
                    begin
                        state_next = S_FLAG;
                    end
                end
            end
            S_FILL:
            begin
                // one copy of the repeated flag per cycle
                mem_ctl.flag_we = 1'b1;
                flag_wdata      = rep_flag_reg;
                cur_next        = CW'(cur_inc);
                rep_cnt_next    = rep_cnt_reg - 8'd1;
                if (rep_cnt_reg == 8'd1)
                begin
                    if (cur_inc >= {1'b0, total_reg})
                    begin
                        cur_next   = '0;
                        rx_next    = '0;
                        bc_next    = '0;
                        state_next = S_XRD;
                    end
                    else
                    begin
                        state_next = S_FLAG;
                    end
                end
            end
            S_XRD:
            begin
                if (cur_reg >= total_reg)
                begin
                    cur_next   = '0;
                    ry_next    = '0;
                    bc_next    = '0;
                    state_next = S_YRD;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = S_XCHK;
                end
            end
            S_XCHK:
            begin
                // points that repeat the previous x take no byte
                if (flag_rd[tsgd_pkg::FL_X_SHORT] || !flag_rd[tsgd_pkg::FL_X_SAME])
                begin
                    state_next = S_XIN;
                end
                else
                begin
                    mem_ctl.x_we = 1'b1;
                    cur_next     = CW'(cur_inc);
                    state_next   = S_XRD;
                end
            end
            S_XIN:
            begin
                if (in_fire)
                begin
                    if (delta_done)
                    begin
                        rx_next      = x_new;
                        mem_ctl.x_we = 1'b1;
                        x_wdata      = x_new;
                        cur_next     = CW'(cur_inc);
                        bc_next      = '0;
                        state_next   = S_XRD;
                    end
                    else
                    begin
                        high_next = data_byte;
                        bc_next   = 16'd1;
                    end
                end
            end
            S_YRD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_YIN;
            end
            S_YIN:
            begin
                if (in_fire)
                begin
                    if (y_skip || delta_done)
                    begin
                        ry_next         = y_new;
                        res_valid       = 1'b1;
                        res.point_x     = x_rd;
                        res.point_y     = y_new;
                        res.on_curve    = flag_rd[tsgd_pkg::FL_ON_CURVE];
                        res.point_index = 16'(cur_reg);
                        res.last_point  = (cur_inc == {1'b0, total_reg});
                        res.status      = tsgd_pkg::ST_OK;
                        cur_next        = CW'(cur_inc);
                        bc_next         = '0;
                        state_next      = (cur_inc >= {1'b0, total_reg}) ? S_IDLE : S_YRD;
                    end
                    else
                    begin
                        high_next = data_byte;
                        bc_next   = 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bc_reg       <= '0;
            cc_reg       <= '0;
            total_reg    <= '0;
            instr_reg    <= '0;
            cur_reg      <= '0;
            rep_flag_reg <= '0;
            rep_cnt_reg  <= '0;
            high_reg     <= '0;
            rx_reg       <= '0;
            ry_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            bc_reg       <= bc_next;
            cc_reg       <= cc_next;
            total_reg    <= total_next;
            instr_reg    <= instr_next;
            cur_reg      <= cur_next;
            rep_flag_reg <= rep_flag_next;
            rep_cnt_reg  <= rep_cnt_next;
            high_reg     <= high_next;
            rx_reg       <= rx_next;
            ry_reg       <= ry_next;
        end
    end

endmodule

// ===== rtl/truetype_simple_glyph_decoder.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | data_byte, glyph_start
// out     | output    | out_valid / out_ready| point_x, point_y, on_curve, point_index,
//         |           |                      | last_point, status
// header, endpoint, instruction, flag and coordinate bytes are each taken as one request
// a repeat count of n holds in_ready low while S_FILL writes the n copies (one flag store write per cycle)
// the x pass reads the flag (S_XRD) and checks it (S_XCHK) for each point before any x byte,
// and leaves through S_XRD; each y request waits in S_YRD for the flag and x read
// reset is asynchronous; the stores need no clearing, they are read only where written
// input stalls while a result waits in the output register and out_ready is low
// depends on tsgd_pkg, tsgd_ctrl, tsgd_store
`timescale 1ns / 1ps

module truetype_simple_glyph_decoder #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               glyph_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               on_curve,
    output logic [15:0]        point_index,
    output logic               last_point,
    output logic [1:0]         status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic               ctrl_ready;
    logic               in_fire;
    logic               res_valid;
    tsgd_pkg::res_t     res;
    tsgd_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         flag_wdata;
    logic [15:0]        x_wdata;
    logic [7:0]         flag_rd;
    logic [15:0]        x_rd;

    logic               out_valid_reg;
    tsgd_pkg::res_t     out_reg;

    assign in_ready = ctrl_ready && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    tsgd_ctrl #(
        .AW         (AW),
        .CW         (CW),
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (data_byte),
        .glyph_start (glyph_start),
        .ready       (ctrl_ready),
        .res_valid   (res_valid),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .flag_wdata  (flag_wdata),
        .x_wdata     (x_wdata),
        .flag_rd     (flag_rd),
        .x_rd        (x_rd)
    );

    tsgd_store #(
        .AW (AW)
    ) u_store (
        .clk        (clk),
        .ctl        (mem_ctl),
        .addr       (mem_addr),
        .flag_wdata (flag_wdata),
        .x_wdata    (x_wdata),
        .flag_rd    (flag_rd),
        .x_rd       (x_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = out_reg.point_x;
    assign point_y     = out_reg.point_y;
    assign on_curve    = out_reg.on_curve;
    assign point_index = out_reg.point_index;
    assign last_point  = out_reg.last_point;
    assign status      = out_reg.status;

endmodule

// ===== rtl/tsgd_checker.sv =====
// tsgd_checker: port level checks of the glyph decoder, bound to the top level
// depends on truetype_simple_glyph_decoder
`timescale 1ns / 1ps

module tsgd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [15:0] point_x,
    input logic signed [15:0] point_y,
    input logic              on_curve,
    input logic [15:0]       point_index,
    input logic              last_point,
    input logic [1:0]        status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
        && $stable(point_index) && $stable(status))
        else $error("stalled result changed");

    // no new request while the output slot is full and not being drained
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken with output slot full");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> last_point)
        else $error("error result without last mark");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> point_x == 16'sd0 && point_y == 16'sd0
        && point_index == 16'd0 && !on_curve)
        else $error("error result with nonzero fields");

endmodule

bind truetype_simple_glyph_decoder tsgd_checker u_tsgd_checker (.*);
